### src/brq_pkg.sv
// Shared widths, request and status codes and sequencer states of the block range query engine.
package brq_pkg;

	localparam int INDEX_W  = 10;
	localparam int ANSWER_W = 43;
	localparam int STATUS_W = 2;
	localparam int REQ_W    = 2;
	localparam int MODE_W   = 2;

	localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
	localparam int MODE_SUM_BIT = 1;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NOP   = 2'd3
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_RANGE = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_HEAD,
		FSM_BODY,
		FSM_TAIL,
		FSM_DRAIN
	} fsm_t;

endpackage

### src/brq_if.sv
// Request and result channel interfaces of the block range query engine.
interface brq_req_if import brq_pkg::*; #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [REQ_W-1:0]              req_type;
	logic signed [VALUE_WIDTH-1:0] element_value;
	logic [INDEX_W-1:0]            left_index;
	logic [INDEX_W-1:0]            right_index;

	modport source (
		output valid, req_type, element_value, left_index, right_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, element_value, left_index, right_index,
		output ready
	);
endinterface

interface brq_rsp_if import brq_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [ANSWER_W-1:0] answer;
	logic [STATUS_W-1:0]        status;

	modport source (
		output valid, answer, status,
		input  ready
	);
	modport sink (
		input  valid, answer, status,
		output ready
	);
endinterface

### src/brq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brq_ram import brq_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/block_range_query_engine.sv
// Block range query engine: element store with per-block min/max/sum aggregates.
//
// Requests arrive on the request channel (valid/ready); each gives exactly one
// result on the result channel. A load appends element_value at the next index
// and updates that block's aggregate, a clear empties the array, and a query
// returns the min, max or sum (per query_mode) over left_index..right_index
// inclusive. The query_mode is written through cfg_we/cfg_wdata; the user must do
// so only while idle, which the block itself does not enforce. Loads, clears,
// bad ranges and unused codes are written into the output register as the
// request is taken. A query reads the element memory over the partial block at
// the left end (at most BLOCK_SIZE elements; up to right_index if both ends
// share a block), then the aggregate memory over the whole blocks between,
// then the element memory up to right_index in its block; one entry is read
// per cycle, and the fold takes the read data in the cycle after the read.
// One request is worked on at a time; the next is taken once the sequencer is
// idle and the output register is free or being emptied in that cycle.
// Reset empties the array and sets query_mode to range minimum; memory content
// is left as it is. A stalled receiver holds the result in the output register.
module block_range_query_engine import brq_pkg::*; #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int BLOCK_SIZE  = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	brq_req_if.sink           request,
	brq_rsp_if.source         result,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata
);

	localparam int AW     = $clog2(ARRAY_DEPTH);
	localparam int CNT_W  = $clog2(ARRAY_DEPTH + 1);
	localparam int OW     = $clog2(BLOCK_SIZE);
	localparam int BLOCKS = (ARRAY_DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int BW     = BLOCKS > 1 ? $clog2(BLOCKS) : 1;
	localparam int TOT_W  = VALUE_WIDTH + OW + 1;
	localparam int SUM_W  = VALUE_WIDTH + AW + 1;
	localparam int AGG_W  = 2 * VALUE_WIDTH + TOT_W;
	localparam int EXT_W  = SUM_W > ANSWER_W ? SUM_W : ANSWER_W;
	localparam int CMP_W  = CNT_W > INDEX_W ? CNT_W : INDEX_W;

	fsm_t fsm_q, fsm_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [MODE_W-1:0] mode_q;

	// aggregate of the block currently being filled
	logic signed [VALUE_WIDTH-1:0] agg_mn_q, agg_mx_q;
	logic signed [TOT_W-1:0]       agg_tot_q;
	logic signed [VALUE_WIDTH-1:0] new_mn, new_mx;
	logic signed [TOT_W-1:0]       new_tot;

	logic [INDEX_W-1:0] idx_q, idx_d, end_q, end_d, blk_q, blk_d, rb_q, r_q;
	logic               same_q, body_q;

	logic rd_vld_s1, rd_agg_s1;
	logic first_q;
	logic signed [SUM_W-1:0] acc_q, acc_d;

	logic                       out_vld_q;
	logic signed [ANSWER_W-1:0] answer_q;
	status_t                    status_q;

	logic          take, full, bad, blk_first, do_load, start_query, out_load;
	logic          scan_elem, scan_agg;
	req_kind_t     kind;
	status_t       status_d;
	logic [INDEX_W-1:0] l_idx, r_idx, lb, rb;

	logic [VALUE_WIDTH-1:0] elem_rdata;
	logic [AGG_W-1:0]       agg_rdata;

	logic mode_sum, mode_max;
	logic signed [SUM_W-1:0] elem_ext, mn_ext, mx_ext, tot_ext, fold_val, folded;
	logic signed [EXT_W-1:0] acc_ext;

	// ---- request decode ----
	assign request.ready = (fsm_q == FSM_IDLE) && (!out_vld_q || result.ready);
	assign take  = request.valid && request.ready;
	assign kind  = req_kind_t'(request.req_type);
	assign l_idx = request.left_index;
	assign r_idx = request.right_index;
	assign lb    = l_idx >> OW;
	assign rb    = r_idx >> OW;
	assign full  = cnt_q == CNT_W'(ARRAY_DEPTH);
	assign bad   = (l_idx > r_idx) || (CMP_W'(r_idx) >= CMP_W'(cnt_q));
	assign blk_first = (cnt_q & CNT_W'(BLOCK_SIZE - 1)) == '0;

	assign do_load     = take && (kind == REQ_LOAD) && !full;
	assign start_query = take && (kind == REQ_QUERY) && !bad;

	always_comb begin
		status_d = STS_OK;
		unique case (kind)
			REQ_LOAD: begin
				if (full) begin
					status_d = STS_FULL;
				end
			end
			REQ_QUERY: begin
				if (bad) begin
					status_d = STS_RANGE;
				end
			end
			REQ_CLEAR: status_d = STS_OK;
			REQ_NOP:   status_d = STS_OK;
			default:   status_d = STS_OK;
		endcase
	end

	// ---- load path: aggregate of the open block is kept in registers ----
	always_comb begin
		if (blk_first) begin
			new_mn  = request.element_value;
			new_mx  = request.element_value;
			new_tot = TOT_W'(request.element_value);
		end else begin
			new_mn  = request.element_value < agg_mn_q ? request.element_value : agg_mn_q;
			new_mx  = request.element_value > agg_mx_q ? request.element_value : agg_mx_q;
			new_tot = agg_tot_q + TOT_W'(request.element_value);
		end
	end

	// ---- scan sequencer ----
	always_comb begin
		fsm_d     = fsm_q;
		idx_d     = idx_q;
		end_d     = end_q;
		blk_d     = blk_q;
		scan_elem = 1'b0;
		scan_agg  = 1'b0;
		unique case (fsm_q)
			FSM_IDLE: begin
				if (start_query) begin
					fsm_d = FSM_HEAD;
					idx_d = l_idx;
					end_d = (lb == rb) ? r_idx : (l_idx | INDEX_W'(BLOCK_SIZE - 1));
				end
			end
			FSM_HEAD: begin
				scan_elem = 1'b1;
				if (idx_q == end_q) begin
					if (same_q) begin
						fsm_d = FSM_DRAIN;
					end else if (body_q) begin
						fsm_d = FSM_BODY;
						blk_d = (idx_q >> OW) + INDEX_W'(1);
					end else begin
						fsm_d = FSM_TAIL;
						idx_d = rb_q << OW;
						end_d = r_q;
					end
				end else begin
					idx_d = idx_q + INDEX_W'(1);
				end
			end
			FSM_BODY: begin
				scan_agg = 1'b1;
				if (blk_q + INDEX_W'(1) == rb_q) begin
					fsm_d = FSM_TAIL;
					idx_d = rb_q << OW;
					end_d = r_q;
				end else begin
					blk_d = blk_q + INDEX_W'(1);
				end
			end
			FSM_TAIL: begin
				scan_elem = 1'b1;
				if (idx_q == end_q) begin
					fsm_d = FSM_DRAIN;
				end else begin
					idx_d = idx_q + INDEX_W'(1);
				end
			end
			FSM_DRAIN: begin
				fsm_d = FSM_IDLE;
			end
			default: begin
				fsm_d = FSM_IDLE;
			end
		endcase
	end

	// ---- memories ----
	brq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (ARRAY_DEPTH)
	) u_elem_ram (
		.clk   (clk),
		.we    (do_load),
		.waddr (AW'(cnt_q)),
		.wdata (request.element_value),
		.re    (scan_elem),
		.raddr (AW'(idx_q)),
		.rdata (elem_rdata)
	);

	brq_ram #(
		.WIDTH (AGG_W),
		.DEPTH (BLOCKS)
	) u_agg_ram (
		.clk   (clk),
		.we    (do_load),
		.waddr (BW'(cnt_q >> OW)),
		.wdata ({new_mn, new_mx, new_tot}),
		.re    (scan_agg),
		.raddr (BW'(blk_q)),
		.rdata (agg_rdata)
	);

	// ---- fold, in the cycle after the read ----
	assign mode_sum = mode_q[MODE_SUM_BIT];
	assign mode_max = !mode_sum && (mode_q == MODE_MAX);

	assign elem_ext = SUM_W'($signed(elem_rdata));
	assign mn_ext   = SUM_W'($signed(agg_rdata[AGG_W-1 -: VALUE_WIDTH]));
	assign mx_ext   = SUM_W'($signed(agg_rdata[TOT_W +: VALUE_WIDTH]));
	assign tot_ext  = SUM_W'($signed(agg_rdata[TOT_W-1:0]));

	always_comb begin
		if (!rd_agg_s1) begin
			fold_val = elem_ext;
		end else if (mode_sum) begin
			fold_val = tot_ext;
		end else if (mode_max) begin
			fold_val = mx_ext;
		end else begin
			fold_val = mn_ext;
		end

		if (mode_sum) begin
			folded = acc_q + fold_val;
		end else if (mode_max) begin
			folded = fold_val > acc_q ? fold_val : acc_q;
		end else begin
			folded = fold_val < acc_q ? fold_val : acc_q;
		end

		acc_d = acc_q;
		if (rd_vld_s1) begin
			acc_d = first_q ? fold_val : folded;
		end
	end

	assign acc_ext  = EXT_W'(acc_d);
	assign out_load = (take && !start_query) || (fsm_q == FSM_DRAIN);

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= FSM_IDLE;
			cnt_q     <= '0;
			mode_q    <= MODE_MIN;
			out_vld_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			fsm_q     <= fsm_d;
			rd_vld_s1 <= scan_elem || scan_agg;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (do_load) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (take && kind == REQ_CLEAR) begin
				cnt_q <= '0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		end_q     <= end_d;
		blk_q     <= blk_d;
		rd_agg_s1 <= scan_agg;
		acc_q     <= acc_d;
		if (rd_vld_s1) begin
			first_q <= 1'b0;
		end
		if (start_query) begin
			r_q     <= r_idx;
			rb_q    <= rb;
			same_q  <= lb == rb;
			body_q  <= (lb + INDEX_W'(1)) < rb;
			first_q <= 1'b1;
		end
		if (do_load) begin
			agg_mn_q  <= new_mn;
			agg_mx_q  <= new_mx;
			agg_tot_q <= new_tot;
		end
		if (fsm_q == FSM_DRAIN) begin
			answer_q <= acc_ext[ANSWER_W-1:0];
			status_q <= STS_OK;
		end else if (take) begin
			answer_q <= '0;
			status_q <= status_d;
		end
	end

	assign result.valid  = out_vld_q;
	assign result.answer = answer_q;
	assign result.status = status_q;

endmodule
